// ----- hw/rtl/ipvrs_pkg.sv -----
package ipvrs_pkg;

	localparam int OP_W  = 2;
	localparam int SET_W = 6;
	localparam int WAY_W = 4;
	localparam int POS_W = 4;
	localparam int PV_W  = 64;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_PROMOTION = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INSERTION = 1'd1;

	localparam logic [PV_W-1:0]  PV_RESET  = '0;
	localparam logic [POS_W-1:0] INS_RESET = 4'd3;

	typedef enum logic [OP_W-1:0] {
		OP_HIT   = 2'd0,
		OP_FILL  = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} back_state_t;

	typedef struct packed {
		op_t              op;
		logic             set_ok;
		logic [SET_W-1:0] set_index;
		logic [WAY_W-1:0] way;
	} item_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

	// position for a hit at recency idx
	function automatic logic [POS_W-1:0] pv_nibble(input logic [PV_W-1:0] pv,
		input logic [POS_W-1:0] idx);
		logic [PV_W-1:0] sh;
		sh = pv >> {idx, 2'b00};
		return sh[POS_W-1:0];
	endfunction

endpackage

// ----- hw/rtl/ipvrs_if.sv -----
interface ipvrs_req_if;
	logic                         valid;
	logic                         ready;
	logic [ipvrs_pkg::OP_W-1:0]   op;
	logic [ipvrs_pkg::SET_W-1:0]  set_index;
	logic [ipvrs_pkg::WAY_W-1:0]  way;

	modport source (output valid, output op, output set_index, output way, input ready);
	modport sink (input valid, input op, input set_index, input way, output ready);
endinterface

interface ipvrs_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [ipvrs_pkg::WAY_W-1:0]  victim_way;

	modport source (output valid, output victim_way, input ready);
	modport sink (input valid, input victim_way, output ready);
endinterface

// ----- hw/rtl/ipvrs_front.sv -----
module ipvrs_front #(
	parameter int WAYS = 16,
	parameter int SETS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ipvrs_req_if.sink             req,
	input  ipvrs_pkg::back_stat_t stat,
	output logic                  item_valid,
	input  logic                  item_ready,
	output ipvrs_pkg::item_t      item
);

	ipvrs_pkg::item_t fifo_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;

	ipvrs_pkg::item_t cls;
	logic             keep;
	logic             set_ok;
	logic             way_ok;
	logic             push;
	logic             pop;

	assign set_ok = (int'(req.set_index) < SETS);
	assign way_ok = (int'(req.way) < WAYS);

	always_comb begin
		cls.op        = ipvrs_pkg::op_t'(req.op);
		cls.set_ok    = set_ok;
		cls.set_index = req.set_index;
		cls.way       = req.way;
		case (req.op)
			ipvrs_pkg::OP_HIT, ipvrs_pkg::OP_FILL: keep = set_ok && way_ok;
			ipvrs_pkg::OP_QUERY: keep = 1'b1;
			default: keep = 1'b0;
		endcase
	end

	assign req.ready  = !stat.clearing && (cnt_q != 2'd2);
	assign push       = req.valid && req.ready && keep;
	assign item_valid = (cnt_q != 2'd0);
	assign item       = fifo_q[rd_ptr_q];
	assign pop        = item_valid && item_ready;

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- hw/rtl/ipvrs_back.sv -----
module ipvrs_back #(
	parameter int WAYS = 16,
	parameter int SETS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  ipvrs_pkg::item_t             item,
	input  logic [ipvrs_pkg::PV_W-1:0]   pv,
	input  logic [ipvrs_pkg::POS_W-1:0]  ins,
	output ipvrs_pkg::back_stat_t        stat,
	ipvrs_rsp_if.source                  rsp
);

	localparam int RW     = $clog2(WAYS + 1);
	localparam int LV     = $clog2(WAYS);
	localparam int WP     = 1 << LV;
	localparam int SET_AW = (SETS > 1) ? $clog2(SETS) : 1;
	localparam logic [RW-1:0]     INVALID  = RW'(WAYS);
	localparam logic [RW-1:0]     LAST_POS = RW'(WAYS - 1);
	localparam logic [SET_AW-1:0] LAST_SET = SET_AW'(SETS - 1);

	typedef logic [WAYS-1:0][RW-1:0] row_t;

	row_t mem [SETS];

	ipvrs_pkg::back_state_t state_q, state_d;
	logic [SET_AW-1:0]      clr_q;
	ipvrs_pkg::item_t       cur_q;
	row_t                   rd_row_q;
	logic                   rsp_valid_q;
	logic [ipvrs_pkg::WAY_W-1:0] victim_q;

	logic              rd_en;
	logic [SET_AW-1:0] rd_addr;
	logic              wr_en;
	logic [SET_AW-1:0] wr_addr;
	row_t              wr_row;
	logic              load_out;
	logic              out_free;

	logic [LV-1:0]       way_idx;
	logic [RW-1:0]       r;
	logic                r_valid;
	logic [ipvrs_pkg::POS_W-1:0] nib;
	logic [RW-1:0]       hit_pos;
	logic [RW-1:0]       ins_pos;
	logic [RW-1:0]       lo;
	logic [RW-1:0]       hi;
	row_t                new_row;
	logic                is_fill;

	logic [RW-1:0] tv [LV+1][WP];
	logic [LV-1:0] ti [LV+1][WP];

	// row update for hit or fill
	always_comb begin
		is_fill = (cur_q.op == ipvrs_pkg::OP_FILL);
		way_idx = cur_q.way[LV-1:0];
		r       = rd_row_q[way_idx];
		r_valid = (r != INVALID);
		nib     = ipvrs_pkg::pv_nibble(pv, ipvrs_pkg::POS_W'(r));
		hit_pos = (int'(nib) >= WAYS) ? LAST_POS : RW'(nib);
		ins_pos = (int'(ins) >= WAYS) ? LAST_POS : RW'(ins);
		lo      = is_fill ? ins_pos : hit_pos;
		hi      = is_fill ? INVALID : r;
		for (int w = 0; w < WAYS; w++) begin
			if (rd_row_q[w] >= lo && rd_row_q[w] < hi) new_row[w] = rd_row_q[w] + 1'b1;
			else new_row[w] = rd_row_q[w];
		end
		new_row[way_idx] = lo;
	end

	// victim: registered row through a max tree, left wins ties
	always_comb begin
		for (int l = 0; l <= LV; l++) begin
			for (int i = 0; i < WP; i++) begin
				tv[l][i] = '0;
				ti[l][i] = '0;
			end
		end
		for (int i = 0; i < WP; i++) begin
			if (i < WAYS) tv[0][i] = rd_row_q[i];
			ti[0][i] = LV'(i);
		end
		for (int l = 0; l < LV; l++) begin
			for (int i = 0; i < (WP >> (l + 1)); i++) begin
				if (tv[l][2*i+1] > tv[l][2*i]) begin
					tv[l+1][i] = tv[l][2*i+1];
					ti[l+1][i] = ti[l][2*i+1];
				end else begin
					tv[l+1][i] = tv[l][2*i];
					ti[l+1][i] = ti[l][2*i];
				end
			end
		end
	end

	assign out_free = !rsp_valid_q || rsp.ready;

	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = SET_AW'(item.set_index);
		wr_en      = 1'b0;
		wr_addr    = SET_AW'(cur_q.set_index);
		wr_row     = new_row;
		load_out   = 1'b0;
		case (state_q)
			ipvrs_pkg::ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				for (int w = 0; w < WAYS; w++) wr_row[w] = INVALID;
				if (clr_q == LAST_SET) state_d = ipvrs_pkg::ST_IDLE;
			end
			ipvrs_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					rd_en   = item.set_ok;
					state_d = ipvrs_pkg::ST_EXEC;
				end
			end
			ipvrs_pkg::ST_EXEC: begin
				case (cur_q.op)
					ipvrs_pkg::OP_QUERY: begin
						if (out_free) begin
							load_out = 1'b1;
							state_d  = ipvrs_pkg::ST_IDLE;
						end
					end
					ipvrs_pkg::OP_FILL: begin
						wr_en   = 1'b1;
						state_d = ipvrs_pkg::ST_IDLE;
					end
					default: begin
						wr_en   = r_valid;
						state_d = ipvrs_pkg::ST_IDLE;
					end
				endcase
			end
			default: state_d = ipvrs_pkg::ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_row;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_row_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) cur_q <= item;
		if (load_out) victim_q <= cur_q.set_ok ? ipvrs_pkg::WAY_W'(ti[LV][0]) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ipvrs_pkg::ST_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ipvrs_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (load_out) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	assign stat.clearing  = (state_q == ipvrs_pkg::ST_CLEAR);
	assign rsp.valid      = rsp_valid_q;
	assign rsp.victim_way = victim_q;

endmodule

// ----- hw/rtl/ipv_recency_stack_replacement.sv -----
// The memory side works on one hit, fill or query at a time: it reads the set row, then writes it back or loads
// the result, before it takes the next item, hits on invalid ways included. Unused ops, and hits and fills to
// out-of-range sets or ways, are dropped at intake, one per cycle while the queue has room and no clearing
// pass runs. A 2-entry queue sits between request intake and the memory side.
// Reset: arst_n clears control state; a clearing pass then marks every way of every set invalid, with
// req.ready low meanwhile. Configuration writes are taken at any time.
module ipv_recency_stack_replacement #(
	parameter int WAYS = 16,
	parameter int SETS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ipvrs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ipvrs_pkg::CFG_DATA_W-1:0]   cfg_data,
	ipvrs_req_if.sink                          req,
	ipvrs_rsp_if.source                        rsp
);

	logic [ipvrs_pkg::PV_W-1:0]  pv_q;
	logic [ipvrs_pkg::POS_W-1:0] ins_q;

	ipvrs_pkg::back_stat_t stat;
	ipvrs_pkg::item_t      item;
	logic                  item_valid;
	logic                  item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q  <= ipvrs_pkg::PV_RESET;
			ins_q <= ipvrs_pkg::INS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ipvrs_pkg::REG_PROMOTION: pv_q <= cfg_data[ipvrs_pkg::PV_W-1:0];
				ipvrs_pkg::REG_INSERTION: ins_q <= cfg_data[ipvrs_pkg::POS_W-1:0];
				default: ;
			endcase
		end
	end

	ipvrs_front #(.WAYS(WAYS), .SETS(SETS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.stat       (stat),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	ipvrs_back #(.WAYS(WAYS), .SETS(SETS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.pv         (pv_q),
		.ins        (ins_q),
		.stat       (stat),
		.rsp        (rsp)
	);

endmodule

// ----- hw/rtl/ipvrs_chk.sv -----
module ipvrs_chk #(
	parameter int WAYS = 16
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            req_valid,
	input logic                            req_ready,
	input logic                            rsp_valid,
	input logic                            rsp_ready,
	input logic [ipvrs_pkg::WAY_W-1:0]     victim_way
);

	// result beat holds until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(victim_way))
		else $error("result beat dropped or changed while stalled");

	a_victim_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (int'(victim_way) < WAYS))
		else $error("victim way out of range");

	// clearing pass follows reset: nothing taken, nothing shown
	a_post_reset: assert property (@(posedge clk)
		!$past(arst_n) |-> !req_ready && !rsp_valid)
		else $error("activity right after reset");

	a_no_stray_ready: assert property (@(posedge clk)
		!arst_n |-> !req_ready || !req_valid)
		else $error("request taken during reset");

endmodule

bind ipv_recency_stack_replacement ipvrs_chk #(.WAYS(WAYS)) u_ipvrs_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.victim_way (rsp.victim_way)
);

// ----- bench/tb_ipv_recency_stack_replacement.sv -----
module tb_ipv_recency_stack_replacement;
	import ipvrs_pkg::*;

	localparam int WAYS = 16;
	localparam int SETS = 64;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int MAX_REPORTS = 10;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_OFF_CYCLES = 400;

	// Shadow copy of the per-set recency stacks; holds the victim ways still owed by the block.
	class recency_shadow;
		logic [4:0]            rec [SETS][WAYS];
		logic [PV_W-1:0]       promo;
		logic [POS_W-1:0]      ins_pos;
		logic [WAY_W-1:0]      victim_q [$];
		int                    mismatches;

		function new();
			foreach (rec[s, w]) rec[s][w] = 5'(WAYS);
			promo = PV_RESET;
			ins_pos = INS_RESET;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_PROMOTION) begin
				promo = data;
			end else begin
				ins_pos = data[POS_W-1:0];
			end
		endfunction

		function int unsigned clamp(int unsigned p);
			return (p >= WAYS) ? WAYS - 1 : p;
		endfunction

		function void bump(int unsigned s, int unsigned lo, int unsigned hi);
			for (int w = 0; w < WAYS; w++) begin
				if (rec[s][w] >= lo && rec[s][w] < hi) begin
					rec[s][w] = rec[s][w] + 5'd1;
				end
			end
		endfunction

		function void note_access(logic [OP_W-1:0] op, logic [SET_W-1:0] s,
			logic [WAY_W-1:0] w);
			int unsigned best;
			int unsigned r;
			int unsigned p;
			best = 0;
			if (op == OP_QUERY) begin
				if (s < SETS) begin
					for (int i = 1; i < WAYS; i++) begin
						if (rec[s][i] > rec[s][best]) best = i;
					end
				end
				victim_q.push_back(WAY_W'(best));
				return;
			end
			if (s >= SETS || w >= WAYS) return;
			if (op == OP_FILL) begin
				p = clamp(ins_pos);
				bump(s, p, WAYS);
				rec[s][w] = 5'(p);
			end else if (op == OP_HIT) begin
				r = rec[s][w];
				if (r >= WAYS) return;
				p = clamp(promo[4*r +: 4]);
				// empty range when p > r: only the hit way moves down
				bump(s, p, r);
				rec[s][w] = 5'(p);
			end
		endfunction

		function void check_victim(logic [WAY_W-1:0] got);
			logic [WAY_W-1:0] want;
			if (victim_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("victim beat %0d arrived with none outstanding", got);
				return;
			end
			want = victim_q.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("victim_way mismatch: expected %0d, got %0d", want, got);
			end
		endfunction

		function int pending();
			return victim_q.size();
		endfunction

		// mostly a way that is currently valid, so hits actually promote
		function logic [WAY_W-1:0] pick_hit_way(logic [SET_W-1:0] s);
			logic [WAY_W-1:0] live [$];
			for (int w = 0; w < WAYS; w++) begin
				if (rec[s][w] < WAYS) live.push_back(WAY_W'(w));
			end
			if (live.size() == 0 || $urandom_range(0, 4) == 0)
				return WAY_W'($urandom_range(0, WAYS - 1));
			return live[$urandom_range(0, live.size() - 1)];
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	bit                     no_idle;
	bit                     hold_off_req;

	ipvrs_req_if req_ch ();
	ipvrs_rsp_if rsp_ch ();

	recency_shadow shadow = new();

	ipv_recency_stack_replacement #(
		.WAYS (WAYS),
		.SETS (SETS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int gap_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 75) return $urandom_range(1, 3);
		if (roll < 95) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int sender_gap();
		if ($urandom_range(0, 99) < 60) return 0;
		return gap_len();
	endfunction

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int stall;
		stall = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall = HOLD_OFF_CYCLES;
			end
			if (stall == 0 && !no_idle && $urandom_range(0, 9) < 2) stall = gap_len();
			if (stall > 0) begin
				stall--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) shadow.check_victim(rsp_ch.victim_way);
	end

	task automatic send(input logic [OP_W-1:0] op, input logic [SET_W-1:0] s,
		input logic [WAY_W-1:0] w);
		int gap;
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.set_index <= s;
		req_ch.way <= w;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		shadow.note_access(op, s, w);
		gap = no_idle ? 0 : sender_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			req_ch.op <= OP_W'($urandom);
			req_ch.set_index <= SET_W'($urandom);
			req_ch.way <= WAY_W'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	// hits and fills give no beat, so allow the pipe to empty after the last victim
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (shadow.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [PV_W-1:0] pv, input logic [POS_W-1:0] ins);
		cfg_we <= 1'b1;
		cfg_index <= REG_PROMOTION;
		cfg_data <= pv;
		@(posedge clk);
		cfg_index <= REG_INSERTION;
		cfg_data <= CFG_DATA_W'(ins);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		shadow.write_reg(REG_PROMOTION, pv);
		shadow.write_reg(REG_INSERTION, CFG_DATA_W'(ins));
	endtask

	task automatic run_phase(input int n_items);
		logic [SET_W-1:0] pool [3];
		logic [OP_W-1:0]  op;
		logic [SET_W-1:0] s;
		logic [WAY_W-1:0] w;
		int               roll;
		foreach (pool[i]) pool[i] = SET_W'($urandom);
		for (int i = 0; i < n_items; i++) begin
			// a few hot sets so the stacks fill up and hits hit valid ways
			s = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 2)] : SET_W'($urandom);
			roll = $urandom_range(0, 99);
			if (roll < 35) begin
				op = OP_FILL;
				w = WAY_W'($urandom);
			end else if (roll < 70) begin
				op = OP_HIT;
				w = shadow.pick_hit_way(s);
			end else if (roll < 95) begin
				op = OP_QUERY;
				w = WAY_W'($urandom);
			end else begin
				op = OP_UNUSED;
				w = WAY_W'($urandom);
			end
			send(op, s, w);
		end
		drain();
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_PROMOTION;
		cfg_data <= '0;
		req_ch.valid <= 1'b0;
		req_ch.op <= OP_HIT;
		req_ch.set_index <= '0;
		req_ch.way <= '0;
		no_idle = 1'b0;
		hold_off_req = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: promote to top, insert at 3
		send(OP_QUERY, 6'd0, 4'd0);
		send(OP_HIT, 6'd0, 4'd5);
		send(OP_FILL, 6'd0, 4'd15);
		send(OP_FILL, 6'd0, 4'd0);
		send(OP_QUERY, 6'd0, 4'd9);
		send(OP_UNUSED, 6'd0, 4'd0);
		send(OP_HIT, 6'd0, 4'd15);
		send(OP_FILL, 6'd0, 4'd15);
		send(OP_QUERY, 6'd0, 4'd0);
		send(OP_FILL, 6'd63, 4'd0);
		send(OP_QUERY, 6'd63, 4'd15);
		drain();

		// every hit demotes to the bottom; fills at top push the bottom way out
		set_config('1, 4'd0);
		send(OP_HIT, 6'd0, 4'd0);
		send(OP_FILL, 6'd0, 4'd7);
		send(OP_QUERY, 6'd0, 4'd0);
		send(OP_HIT, 6'd63, 4'd0);
		send(OP_QUERY, 6'd63, 4'd0);
		drain();

		set_config({$urandom, $urandom}, POS_W'($urandom));
		run_phase(170);
		set_config('0, 4'd0);
		run_phase(170);
		no_idle = 1'b1;
		set_config('1, 4'd15);
		run_phase(170);
		no_idle = 1'b0;
		set_config({$urandom, $urandom}, 4'd3);
		hold_off_req = 1'b1;
		run_phase(170);
		set_config({$urandom, $urandom}, POS_W'($urandom));
		run_phase(170);
		set_config({$urandom, $urandom}, 4'd15);
		run_phase(170);

		if (shadow.mismatches == 0 && shadow.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/ipvrs_pkg.sv
hw/rtl/ipvrs_if.sv
hw/rtl/ipvrs_front.sv
hw/rtl/ipvrs_back.sv
hw/rtl/ipv_recency_stack_replacement.sv
hw/rtl/ipvrs_chk.sv
bench/tb_ipv_recency_stack_replacement.sv
